// ===== src/bzyx_pkg.sv =====
// Shared types and constants for the Bezier y-from-x bisection block.
package bzyx_pkg;

  localparam int COORD_W          = 32;
  localparam int T_W              = 17;
  localparam int T_FRAC           = 16;
  localparam int TOL_W            = 16;
  localparam int ITER_W           = 6;
  localparam int CFG_IDX_W        = 2;
  localparam int PARAM_FRAC_DEF   = 26;
  localparam int STEP_W           = 3;

  localparam logic [T_W-1:0]    T_ONE       = T_W'(1) << T_FRAC;
  localparam logic [TOL_W-1:0]  TOL_RESET   = TOL_W'(1);
  localparam logic [ITER_W-1:0] MAXIT_RESET = ITER_W'(26);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = CFG_IDX_W'(1);

  // de Casteljau step of the last mix
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(5);

  typedef enum logic [2:0] {
    S_IDLE, S_TGT_MUL, S_TGT_ADD, S_MID, S_MUL, S_ADD, S_CMP, S_OUT
  } bzyx_state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_TGT_MUL, OP_TGT_ADD, OP_MID, OP_MIX_MUL, OP_MIX_ADD, OP_CMP
  } bzyx_op_t;

  typedef struct packed {
    bzyx_op_t          op;
    logic [STEP_W-1:0] step;
    logic              sel_y;
    logic              out_load;
  } bzyx_cmd_t;

  typedef struct packed {
    logic conv;
  } bzyx_stat_t;

endpackage

// ===== src/bzyx_ctrl.sv =====
// Sequencer for target setup, bisection steps and the final y evaluation.
module bzyx_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  logic [bzyx_pkg::ITER_W-1:0]   max_iterations,
  output bzyx_pkg::bzyx_cmd_t           cmd,
  input  bzyx_pkg::bzyx_stat_t          stat
);
  import bzyx_pkg::*;

  bzyx_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              sel_y_r, sel_y_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ITER_W-1:0] limit;
  logic [ITER_W:0]   iter_inc;
  logic              out_free;

  assign limit    = (max_iterations == '0) ? ITER_W'(1) : max_iterations;
  assign iter_inc = {1'b0, iter_r} + (ITER_W+1)'(1);
  assign out_free = !out_valid_r || !out_stall;

  // next state and counters
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    iter_nxt      = iter_r;
    sel_y_nxt     = sel_y_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_TGT_MUL;
          iter_nxt  = '0;
          sel_y_nxt = 1'b0;
        end
      end
      S_TGT_MUL: state_nxt = S_TGT_ADD;
      S_TGT_ADD: state_nxt = S_MID;
      S_MID: begin
        state_nxt = S_MUL;
        step_nxt  = '0;
      end
      S_MUL: state_nxt = S_ADD;
      S_ADD: begin
        if (step_r == STEP_LAST) begin
          state_nxt = sel_y_r ? S_OUT : S_CMP;
        end else begin
          state_nxt = S_MUL;
          step_nxt  = step_r + STEP_W'(1);
        end
      end
      S_CMP: begin
        iter_nxt = iter_inc[ITER_W-1:0];
        if (stat.conv || iter_inc >= {1'b0, limit}) begin
          state_nxt = S_MUL;
          step_nxt  = '0;
          sel_y_nxt = 1'b1;
        end else begin
          state_nxt = S_MID;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.step     = step_r;
    cmd.sel_y    = sel_y_r;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_IDLE:    cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_TGT_MUL: cmd.op = OP_TGT_MUL;
      S_TGT_ADD: cmd.op = OP_TGT_ADD;
      S_MID:     cmd.op = OP_MID;
      S_MUL:     cmd.op = OP_MIX_MUL;
      S_ADD:     cmd.op = OP_MIX_ADD;
      S_CMP:     cmd.op = OP_CMP;
      S_OUT:     cmd.out_load = out_free;
      default:   cmd.op = OP_NONE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      iter_r      <= '0;
      sel_y_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      iter_r      <= iter_nxt;
      sel_y_r     <= sel_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/bzyx_dp.sv =====
// Datapath: point registers, shared mix multiplier, bisection bounds, output word.
module bzyx_dp #(
  parameter int PARAM_FRAC_BITS = bzyx_pkg::PARAM_FRAC_DEF
) (
  input  logic                                clk,
  input  bzyx_pkg::bzyx_cmd_t                 cmd,
  output bzyx_pkg::bzyx_stat_t                stat,
  input  logic signed [bzyx_pkg::COORD_W-1:0] px_in [4],
  input  logic signed [bzyx_pkg::COORD_W-1:0] py_in [4],
  input  logic [bzyx_pkg::T_W-1:0]            t_in,
  input  logic [bzyx_pkg::TOL_W-1:0]          tolerance,
  output logic signed [bzyx_pkg::COORD_W-1:0] y_value,
  output logic                                converged
);
  import bzyx_pkg::*;

  localparam int UW = (PARAM_FRAC_BITS + 1 > T_W) ? PARAM_FRAC_BITS + 1 : T_W;
  localparam int PW = COORD_W + 2 + UW;
  localparam int DW = COORD_W + 1;

  logic signed [COORD_W-1:0] px_r [4];
  logic signed [COORD_W-1:0] py_r [4];
  logic signed [COORD_W-1:0] m_r  [5];
  logic [T_W-1:0]            t_r;
  logic signed [COORD_W-1:0] tgt_r, res_r, out_y_r;
  logic [PARAM_FRAC_BITS:0]  lo_r, hi_r, u_r, mid;
  logic [PARAM_FRAC_BITS+1:0] bsum;
  logic signed [PW-1:0]      prod_r;
  logic                      conv_r, out_conv_r, conv_now;

  logic signed [COORD_W-1:0] opa, opb;
  logic signed [DW-1:0]      mul_a;
  logic [UW-1:0]             mul_b;
  logic signed [PW-1:0]      prod_shift;
  logic signed [COORD_W-1:0] base;
  logic signed [DW-1:0]      diff;
  logic [DW-1:0]             adiff;

  // operand pair of the current de Casteljau step
  always_comb begin
    case (cmd.step)
      3'd0:    begin opa = cmd.sel_y ? py_r[0] : px_r[0]; opb = cmd.sel_y ? py_r[1] : px_r[1]; end
      3'd1:    begin opa = cmd.sel_y ? py_r[1] : px_r[1]; opb = cmd.sel_y ? py_r[2] : px_r[2]; end
      3'd2:    begin opa = cmd.sel_y ? py_r[2] : px_r[2]; opb = cmd.sel_y ? py_r[3] : px_r[3]; end
      3'd3:    begin opa = m_r[0]; opb = m_r[1]; end
      3'd4:    begin opa = m_r[1]; opb = m_r[2]; end
      default: begin opa = m_r[3]; opb = m_r[4]; end
    endcase
  end

  // shared multiplier: target mix uses t, curve mixes use u
  always_comb begin
    if (cmd.op == OP_TGT_MUL) begin
      mul_a = DW'(px_r[3]) - DW'(px_r[0]);
      mul_b = UW'(t_r);
    end else begin
      mul_a = DW'(opb) - DW'(opa);
      mul_b = UW'(u_r);
    end
  end

  assign prod_shift = (cmd.op == OP_TGT_ADD) ? (prod_r >>> T_FRAC)
                                             : (prod_r >>> PARAM_FRAC_BITS);
  assign base = (cmd.op == OP_TGT_ADD) ? px_r[0] : opa;

  // bisection midpoint and convergence test
  assign bsum     = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = bsum[PARAM_FRAC_BITS+1:1];
  assign diff     = DW'(res_r) - DW'(tgt_r);
  assign adiff    = diff[DW-1] ? DW'(-diff) : diff;
  assign conv_now = adiff <= DW'(tolerance);
  assign stat.conv = conv_now;

  always_ff @(posedge clk) begin
    case (cmd.op) inside
      OP_LOAD: begin
        px_r <= px_in;
        py_r <= py_in;
        t_r  <= (t_in > T_ONE) ? T_ONE : t_in;
        lo_r <= '0;
        hi_r <= (PARAM_FRAC_BITS+1)'(1) << PARAM_FRAC_BITS;
      end
      OP_TGT_MUL, OP_MIX_MUL: prod_r <= PW'(mul_a) * PW'($signed({1'b0, mul_b}));
      OP_TGT_ADD: tgt_r <= base + prod_shift[COORD_W-1:0];
      OP_MID:     u_r <= mid;
      OP_MIX_ADD: begin
        if (cmd.step == STEP_LAST) begin
          res_r <= base + prod_shift[COORD_W-1:0];
        end else begin
          m_r[cmd.step] <= base + prod_shift[COORD_W-1:0];
        end
      end
      OP_CMP: begin
        if (res_r < tgt_r) begin
          lo_r <= u_r;
        end else begin
          hi_r <= u_r;
        end
        conv_r <= conv_now;
      end
      default: ;
    endcase
    // output word moves only when the output register is free
    if (cmd.out_load) begin
      out_y_r    <= res_r;
      out_conv_r <= conv_r;
    end
  end

  assign y_value   = out_y_r;
  assign converged = out_conv_r;

endmodule

// ===== src/bezier_y_from_x_bisection.sv =====
// Top level: cubic Bezier keyframe y at a fraction of the x span, by bisection.
// Sequence per word: target setup (multiply, then add), then 1..max_iterations bisection
// steps (a limit of 0 acts as 1), each a midpoint, six multiply-then-add mixes on the
// one shared multiplier and a compare; then the same mixes for y and the output load.
// One word at a time: a new word is taken only once the last has left the sequencer.
// Reset (synchronous, rst_n low) idles the sequencer, drops out_valid, loads
// tolerance = 1 and max_iterations = 26.
module bezier_y_from_x_bisection #(
  parameter int PARAM_FRAC_BITS = bzyx_pkg::PARAM_FRAC_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [bzyx_pkg::COORD_W-1:0]   in_start_x,
  input  logic signed [bzyx_pkg::COORD_W-1:0]   in_start_y,
  input  logic signed [bzyx_pkg::COORD_W-1:0]   in_start_handle_x,
  input  logic signed [bzyx_pkg::COORD_W-1:0]   in_start_handle_y,
  input  logic signed [bzyx_pkg::COORD_W-1:0]   in_end_handle_x,
  input  logic signed [bzyx_pkg::COORD_W-1:0]   in_end_handle_y,
  input  logic signed [bzyx_pkg::COORD_W-1:0]   in_end_x,
  input  logic signed [bzyx_pkg::COORD_W-1:0]   in_end_y,
  input  logic [bzyx_pkg::T_W-1:0]              in_t_frac,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [bzyx_pkg::COORD_W-1:0]   out_y_value,
  output logic                                  out_converged,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bzyx_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bzyx_pkg::TOL_W-1:0]            cfg_data
);
  import bzyx_pkg::*;

  logic [TOL_W-1:0]  tolerance_r;
  logic [ITER_W-1:0] max_iter_r;
  bzyx_cmd_t         cmd;
  bzyx_stat_t        stat;
  logic signed [COORD_W-1:0] px [4];
  logic signed [COORD_W-1:0] py [4];

  assign px = '{in_start_x, in_start_handle_x, in_end_handle_x, in_end_x};
  assign py = '{in_start_y, in_start_handle_y, in_end_handle_y, in_end_y};

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r <= TOL_RESET;
      max_iter_r  <= MAXIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TOLERANCE: tolerance_r <= cfg_data;
        REG_MAX_ITER:  max_iter_r  <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  bzyx_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .max_iterations (max_iter_r),
    .cmd            (cmd),
    .stat           (stat)
  );

  bzyx_dp #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .stat      (stat),
    .px_in     (px),
    .py_in     (py),
    .t_in      (in_t_frac),
    .tolerance (tolerance_r),
    .y_value   (out_y_value),
    .converged (out_converged)
  );

endmodule

// ===== src/bzyx_checker.sv =====
// Port-level checks for the Bezier y-from-x block, bound to the top level.
module bzyx_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [bzyx_pkg::COORD_W-1:0] out_y_value,
  input logic                                out_converged
);

  // a held result word keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_y_value) && $stable(out_converged))
    else $error("result word changed while stalled");

  // once a word is taken the block is busy with it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // no result can appear in the cycle right after an accept
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early");

  // reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind bezier_y_from_x_bisection bzyx_checker u_bzyx_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_y_value   (out_y_value),
  .out_converged (out_converged)
);

// ===== sim/bezier_y_from_x_bisection_tb.sv =====
// Self-checking testbench for the Bezier y-from-x bisection block.
`timescale 1ns / 1ps

module bezier_y_from_x_bisection_tb;
  import bzyx_pkg::*;

  localparam int PFRAC     = PARAM_FRAC_DEF;
  localparam int WDOG_MAX  = 40000;
  localparam int LONG_HOLD = 400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  typedef struct {
    logic signed [COORD_W-1:0] x0, y0, x1, y1, x2, y2, x3, y3;
    logic [T_W-1:0]            t;
  } segment_t;

  typedef struct {
    logic signed [COORD_W-1:0] y;
    logic                      conv;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] in_start_x = '0, in_start_y = '0;
  logic signed [COORD_W-1:0] in_start_handle_x = '0, in_start_handle_y = '0;
  logic signed [COORD_W-1:0] in_end_handle_x = '0, in_end_handle_y = '0;
  logic signed [COORD_W-1:0] in_end_x = '0, in_end_y = '0;
  logic [T_W-1:0] in_t_frac = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_y_value;
  logic out_converged;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TOL_W-1:0] cfg_data = '0;

  // predictor copy of the registers
  logic [TOL_W-1:0]  tol_reg = TOL_RESET;
  logic [ITER_W-1:0] iter_reg = MAXIT_RESET;

  sample_t expected_samples[$];
  int  error_count = 0;
  bit  quiet = 0;        // no idling in the closing part
  bit  long_hold_req = 0;
  int  idle_cycles = 0;

  bezier_y_from_x_bisection uut (.*);

  always #10 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic longint lerp_q(longint a, longint b, longint u);
    return a + (((b - a) * u) >>> PFRAC);
  endfunction

  function automatic longint curve_at(longint p0, longint p1, longint p2, longint p3,
                                      longint u);
    longint a, b, c, d, e;
    a = lerp_q(p0, p1, u);
    b = lerp_q(p1, p2, u);
    c = lerp_q(p2, p3, u);
    d = lerp_q(a, b, u);
    e = lerp_q(b, c, u);
    return lerp_q(d, e, u);
  endfunction

  function automatic sample_t predict_sample(segment_t s);
    sample_t r;
    longint lo, hi, u, tt, target, bx, diff;
    int limit, n;
    lo = 0;
    hi = longint'(1) << PFRAC;
    u = 0;
    n = 0;
    tt = (s.t > T_ONE) ? longint'(T_ONE) : longint'(s.t);
    target = longint'(s.x0) + (((longint'(s.x3) - longint'(s.x0)) * tt) >>> T_FRAC);
    limit = (iter_reg == 0) ? 1 : int'(iter_reg);
    do begin
      u = (lo + hi) >>> 1;
      bx = curve_at(s.x0, s.x1, s.x2, s.x3, u);
      if (bx < target) lo = u;
      else hi = u;
      diff = bx - target;
      if (diff < 0) diff = -diff;
      r.conv = (diff <= longint'(tol_reg));
      n++;
    end while (!r.conv && n < limit);
    r.y = COORD_W'(curve_at(s.y0, s.y1, s.y2, s.y3, u));
    return r;
  endfunction

  // ---------------- drivers ----------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic send_segment(segment_t s);
    bit stalled;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_x <= s.x0; in_start_y <= s.y0;
    in_start_handle_x <= s.x1; in_start_handle_y <= s.y1;
    in_end_handle_x <= s.x2; in_end_handle_y <= s.y2;
    in_end_x <= s.x3; in_end_y <= s.y3;
    in_t_frac <= s.t;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    expected_samples.insert(expected_samples.size(), predict_sample(s));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] val);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    if (idx == REG_TOLERANCE) tol_reg = val;
    else if (idx == REG_MAX_ITER) iter_reg = val[ITER_W-1:0];
  endtask

  task automatic set_regs(int tol, int iters);
    wait_drained();
    write_reg(REG_TOLERANCE, TOL_W'(tol));
    write_reg(REG_MAX_ITER, TOL_W'(iters));
  endtask

  function automatic logic signed [COORD_W-1:0] rand_word();
    return COORD_W'($urandom);
  endfunction

  // random content, or x handles kept within the span of the x end points
  function automatic segment_t rand_segment(bit well_formed);
    segment_t s;
    int span;
    s.y0 = rand_word(); s.y1 = rand_word(); s.y2 = rand_word(); s.y3 = rand_word();
    if (well_formed) begin
      span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h3fff_ffff)
                                         : $urandom_range(0, 32'h0010_0000);
      s.x0 = COORD_W'($signed($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000);
      s.x1 = s.x0 + COORD_W'($urandom_range(0, span));
      s.x2 = s.x0 + COORD_W'($urandom_range(0, span));
      s.x3 = s.x0 + COORD_W'(span);
      if ($urandom_range(0, 1)) begin
        s.x1 = s.x0 + s.x3 - s.x1;
        s.x2 = s.x0 + s.x3 - s.x2;
        {s.x0, s.x3} = {s.x3, s.x0};
        {s.x1, s.x2} = {s.x2, s.x1};
      end
      if ($urandom_range(0, 3) == 0) begin
        s.y0 = $signed(s.y0) >>> 8; s.y3 = $signed(s.y3) >>> 8;
      end
    end else begin
      s.x0 = rand_word(); s.x1 = rand_word(); s.x2 = rand_word(); s.x3 = rand_word();
    end
    s.t = ($urandom_range(0, 9) == 0) ? T_W'($urandom) : T_W'($urandom_range(0, T_ONE));
    return s;
  endfunction

  // ---------------- result checker ----------------
  always @(negedge clk) begin
    sample_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected word y_value", out_y_value, 0);
      end else begin
        want = expected_samples.pop_front();
        if (out_y_value !== want.y) report_mismatch("y_value", out_y_value, want.y);
        if (out_converged !== want.conv)
          report_mismatch("converged", out_converged, want.conv);
      end
    end
  end

  // receiver stalls: random bursts, one long hold on request
  always @(posedge clk) begin
    static int burst = 0;
    static bit stall_on = 0;
    if (long_hold_req) begin
      long_hold_req = 0;
      burst = LONG_HOLD;
      stall_on = 1;
    end
    if (quiet && burst == 0) begin
      stall_on = 0;
    end else if (burst == 0) begin
      stall_on = ($urandom_range(0, 2) == 0);
      burst = $urandom_range(1, 7);
    end
    if (burst > 0) burst--;
    out_stall <= stall_on;
  end

  // watchdog on cycles with no handshake at all
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else if (++idle_cycles >= WDOG_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    segment_t s;
    logic signed [COORD_W-1:0] mx, mn;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    // straight line, t at 0, 1, above 1, the all-ones fraction and one half
    s = '{0, 0, 32'sh5555, 32'sh5555, 32'shaaaa, 32'shaaaa, 32'sh10000, 32'sh10000, 0};
    send_segment(s);
    s.t = T_ONE; send_segment(s);
    s.t = T_ONE + 1; send_segment(s);
    s.t = '1; send_segment(s);
    s.t = T_ONE >> 1; send_segment(s);
    // coordinate extremes
    s = '{mn, mx, mn, mx, mx, mn, mx, mn, T_ONE >> 2}; send_segment(s);
    s = '{mx, mn, mx, mn, mn, mx, mn, mx, 3 * (T_ONE >> 2)}; send_segment(s);
    s = '{mx, mx, mx, mx, mx, mx, mx, mx, 1}; send_segment(s);
    s = '{mn, mn, mn, mn, mn, mn, mn, mn, T_ONE - 1}; send_segment(s);
    s = '{-1, -1, 0, 0, -1, -1, 0, 0, 12345}; send_segment(s);
    // degenerate: zero span, decreasing x, handles outside the span
    s = '{100, 7, 100, -7, 100, 9, 100, -9, 40000}; send_segment(s);
    s = '{32'sh40000, 1, 32'sh30000, 2, 32'sh10000, 3, 0, 4, 20000}; send_segment(s);
    s = '{0, 0, 32'sh7000_0000, 5, mn, 6, 32'sh1_0000, 7, 30000}; send_segment(s);
  endtask

  task automatic test_register_corners();
    segment_t s;
    // iteration limit zero acts as one; unlisted index is ignored
    set_regs(0, 0);
    write_reg(REG_UNUSED, '1);
    repeat (3) send_segment(rand_segment(1));
    // limit past parameter precision
    set_regs(0, 63);
    repeat (3) send_segment(rand_segment(1));
    s = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_segment(s);
    set_regs(65535, 1);
    repeat (3) send_segment(rand_segment(1));
    set_regs('hffff, 'hffc0 | 26);
    repeat (3) send_segment(rand_segment(0));
  endtask

  task automatic test_random(int tol, int iters, int count);
    set_regs(tol, iters);
    repeat (count) send_segment(rand_segment($urandom_range(0, 4) != 0));
  endtask

  task automatic test_backpressure();
    wait_drained();
    long_hold_req = 1;
    repeat (6) send_segment(rand_segment(1));
    // sender pauses until everything has come back
    wait_drained();
    repeat (6) send_segment(rand_segment(1));
  endtask

  task automatic test_quiet_tail();
    quiet = 1;
    test_random(1, 26, 40);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_corners();
    test_random(1, 26, 100);
    test_random(0, 32, 70);
    test_random(65535, 6, 60);
    test_random(16, 63, 50);
    test_random($urandom_range(0, 65535), $urandom_range(1, 32), 60);
    test_random(3, 12, 60);
    test_backpressure();
    test_quiet_tail();
    wait_drained();
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/bzyx_pkg.sv
src/bzyx_ctrl.sv
src/bzyx_dp.sv
src/bezier_y_from_x_bisection.sv
src/bzyx_checker.sv
sim/bezier_y_from_x_bisection_tb.sv
